@@ hdl/parallel_port_interface_macros.svh @@
// Assertion macros of the parallel port interface.
`ifndef PARALLEL_PORT_INTERFACE_MACROS_SVH
`define PARALLEL_PORT_INTERFACE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PPI_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("invariant failed");

// A trigger that must be followed by a consequence in the next cycle.
`define PPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/ppi_pkg.sv @@
// Types, codes and helper functions of the parallel port interface.
package ppi_pkg;

    localparam logic [2:0] ACT_BUS_WRITE  = 3'd0;
    localparam logic [2:0] ACT_BUS_READ   = 3'd1;
    localparam logic [2:0] ACT_PINS_A     = 3'd2;
    localparam logic [2:0] ACT_PINS_B     = 3'd3;
    localparam logic [2:0] ACT_PINS_C     = 3'd4;
    localparam logic [2:0] ACT_RESET_LINE = 3'd5;

    localparam logic [1:0] ADDR_PORT_A  = 2'd0;
    localparam logic [1:0] ADDR_PORT_B  = 2'd1;
    localparam logic [1:0] ADDR_PORT_C  = 2'd2;
    localparam logic [1:0] ADDR_CONTROL = 2'd3;

    localparam logic [1:0] MODE_A_BASIC  = 2'd0;
    localparam logic [1:0] MODE_A_STROBE = 2'd1;
    localparam logic [1:0] MODE_A_BIDIR  = 2'd2;

    // Port C handshake bit positions.
    localparam logic [7:0] OBF_A  = 8'h80;
    localparam logic [7:0] ACK_A  = 8'h40;
    localparam logic [7:0] IBF_A  = 8'h20;
    localparam logic [7:0] STB_A  = 8'h10;
    localparam logic [7:0] INTR_A = 8'h08;
    localparam logic [7:0] STB_B  = 8'h04;
    localparam logic [7:0] ACK_B  = 8'h04;
    localparam logic [7:0] IBF_B  = 8'h02;
    localparam logic [7:0] OBF_B  = 8'h02;
    localparam logic [7:0] INTR_B = 8'h01;

    localparam logic [7:0] ALL_INPUTS   = 8'hff;
    localparam logic [7:0] CTRL_READ    = 8'hff;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] address;
        logic [7:0] data;
        logic [7:0] pin_mask;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic [7:0] port_c_drive;
        logic [2:0] drive_updated;
    } t_result;

    typedef struct packed {
        logic [2:0][7:0] lat;
        logic [2:0][7:0] pin;
        logic [2:0][7:0] dir;
        logic [1:0]      a_mode;
        logic            b_mode;
        logic [2:0]      fw;
    } t_state;

    // One port's output latch while an item is being worked out.
    typedef struct packed {
        logic [7:0] lat;
        logic       fw;
        logic       drv;
    } t_port;

    typedef t_port [2:0] t_ports;

    // Drive a port: only a changed value or the first write after reset counts.
    function automatic t_port port_drive(t_port p, logic [7:0] v);
        t_port q;
        q = p;
        if (p.lat != v || p.fw) begin
            q.lat = v;
            q.fw  = 1'b0;
            q.drv = 1'b1;
        end
        return q;
    endfunction

    // Latch write to port A, B or C with the output-buffer handshake on port C.
    function automatic t_ports port_write(t_ports p, logic [1:0] ch, logic [7:0] v,
                                          logic a_hs, logic b_hs);
        t_ports     q;
        logic [7:0] c;
        logic [7:0] w;
        q     = p;
        q[ch] = port_drive(q[ch], v);
        c     = q[2].lat;
        w     = c;
        if (ch == ADDR_PORT_A && a_hs) begin
            w = c & ~OBF_A;
            if ((c & ACK_A) != 8'h00) w = w & ~INTR_A;
            q[2] = port_drive(q[2], w);
        end else if (ch == ADDR_PORT_B && b_hs) begin
            w = c & ~OBF_B;
            if ((c & ACK_B) != 8'h00) w = w & ~INTR_B;
            q[2] = port_drive(q[2], w);
        end
        return q;
    endfunction

    // Strobe or acknowledge pin on port C: a falling edge raises the flag,
    // a rising edge raises the interrupt if its enable bit is set.
    function automatic t_port pin_edge(t_port pc, logic [7:0] old, logic [7:0] data,
                                       logic [7:0] mask, logic [7:0] pin,
                                       logic [7:0] flag, logic [7:0] intr);
        t_port q;
        q = pc;
        if ((mask & pin) != 8'h00) begin
            if ((old & pin) != 8'h00 && (data & pin) == 8'h00) begin
                q = port_drive(pc, pc.lat | flag);
            end else if ((old & pin) == 8'h00 && (data & pin) != 8'h00) begin
                if ((pc.lat & pin) != 8'h00) q = port_drive(pc, pc.lat | intr);
            end
        end
        return q;
    endfunction

endpackage

@@ hdl/ppi_if.sv @@
// Valid/ready channel interfaces of the parallel port interface.
interface ppi_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [1:0] address;
    logic [7:0] data;
    logic [7:0] pin_mask;

    modport source(output valid, action, address, data, pin_mask, input ready);
    modport sink(input valid, action, address, data, pin_mask, output ready);
endinterface

interface ppi_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic [7:0] port_c_drive;
    logic [2:0] drive_updated;

    modport source(output valid, read_data, port_a_drive, port_b_drive, port_c_drive,
                   drive_updated, input ready);
    modport sink(input valid, read_data, port_a_drive, port_b_drive, port_c_drive,
                 drive_updated, output ready);
endinterface

interface ppi_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

@@ hdl/ppi_core.sv @@
// Next-state and result logic for one event of the parallel port interface.
module ppi_core (
    input  ppi_pkg::t_state  i_state,
    input  ppi_pkg::t_item   i_item,
    input  logic             i_clear_on_mode_set,
    output ppi_pkg::t_state  o_state,
    output ppi_pkg::t_result o_result
);

    ppi_pkg::t_ports  p;
    ppi_pkg::t_state  st;
    logic [7:0]       rd;
    logic [7:0]       v;
    logic [1:0]       ch;
    logic             a_hs;
    logic             b_hs;

    assign ch = i_item.address;

    always_comb begin
        st   = i_state;
        rd   = 8'h00;
        v    = 8'h00;
        for (int i = 0; i < 3; i++) begin
            p[i].lat = i_state.lat[i];
            p[i].fw  = i_state.fw[i];
            p[i].drv = 1'b0;
        end
        a_hs = (i_state.a_mode == ppi_pkg::MODE_A_STROBE) ||
               (i_state.a_mode == ppi_pkg::MODE_A_BIDIR);
        b_hs = i_state.b_mode;

        unique case (i_item.action)
            ppi_pkg::ACT_BUS_WRITE: begin
                if (ch != ppi_pkg::ADDR_CONTROL) begin
                    p = ppi_pkg::port_write(p, ch, i_item.data, a_hs, b_hs);
                end else if (i_item.data[7]) begin
                    // Mode word: new modes and directions, then the handshake defaults.
                    st.a_mode = i_item.data[6] ? ppi_pkg::MODE_A_BIDIR
                                               : {1'b0, i_item.data[5]};
                    st.dir[0] = (i_item.data[6] || i_item.data[4]) ? 8'hff : 8'h00;
                    st.b_mode = i_item.data[2];
                    st.dir[1] = i_item.data[1] ? 8'hff : 8'h00;
                    st.dir[2] = {{4{i_item.data[3]}}, {4{i_item.data[0]}}};
                    a_hs      = (st.a_mode == ppi_pkg::MODE_A_STROBE) ||
                                (st.a_mode == ppi_pkg::MODE_A_BIDIR);
                    b_hs      = st.b_mode;
                    if (i_clear_on_mode_set) begin
                        p = ppi_pkg::port_write(p, ppi_pkg::ADDR_PORT_A, 8'h00, a_hs, b_hs);
                        p = ppi_pkg::port_write(p, ppi_pkg::ADDR_PORT_B, 8'h00, a_hs, b_hs);
                        p = ppi_pkg::port_write(p, ppi_pkg::ADDR_PORT_C, 8'h00, a_hs, b_hs);
                    end
                    if (st.a_mode != ppi_pkg::MODE_A_BASIC || st.b_mode) begin
                        v = p[2].lat;
                        if (a_hs) v = (v & ~ppi_pkg::IBF_A & ~ppi_pkg::INTR_A) | ppi_pkg::OBF_A;
                        if (b_hs) begin
                            if (st.dir[1] == ppi_pkg::ALL_INPUTS) v = v & ~ppi_pkg::IBF_B;
                            else v = v | ppi_pkg::OBF_B;
                            v = v & ~ppi_pkg::INTR_B;
                        end
                        p[2] = ppi_pkg::port_drive(p[2], v);
                    end
                end else begin
                    // Single-bit set or clear on port C.
                    v                     = p[2].lat;
                    v[i_item.data[3:1]]   = i_item.data[0];
                    p[2]                  = ppi_pkg::port_drive(p[2], v);
                end
            end
            ppi_pkg::ACT_BUS_READ: begin
                if (ch == ppi_pkg::ADDR_CONTROL) begin
                    rd = ppi_pkg::CTRL_READ;
                end else begin
                    v = p[2].lat;
                    if (ch == ppi_pkg::ADDR_PORT_A && a_hs) begin
                        v = v & ~ppi_pkg::IBF_A;
                        if ((p[2].lat & ppi_pkg::STB_A) != 8'h00) v = v & ~ppi_pkg::INTR_A;
                        p[2] = ppi_pkg::port_drive(p[2], v);
                    end else if (ch == ppi_pkg::ADDR_PORT_B && b_hs) begin
                        v = v & ~ppi_pkg::IBF_B;
                        if ((p[2].lat & ppi_pkg::STB_B) != 8'h00) v = v & ~ppi_pkg::INTR_B;
                        p[2] = ppi_pkg::port_drive(p[2], v);
                    end
                    rd = (i_state.pin[ch] & i_state.dir[ch]) | (p[ch].lat & ~i_state.dir[ch]);
                end
            end
            ppi_pkg::ACT_PINS_A: begin
                st.pin[0] = (i_state.pin[0] & ~i_item.pin_mask) |
                            (i_item.data & i_item.pin_mask);
            end
            ppi_pkg::ACT_PINS_B: begin
                st.pin[1] = (i_state.pin[1] & ~i_item.pin_mask) |
                            (i_item.data & i_item.pin_mask);
            end
            ppi_pkg::ACT_PINS_C: begin
                if (a_hs) begin
                    p[2] = ppi_pkg::pin_edge(p[2], i_state.pin[2], i_item.data,
                                             i_item.pin_mask, ppi_pkg::STB_A,
                                             ppi_pkg::IBF_A, ppi_pkg::INTR_A);
                    p[2] = ppi_pkg::pin_edge(p[2], i_state.pin[2], i_item.data,
                                             i_item.pin_mask, ppi_pkg::ACK_A,
                                             ppi_pkg::OBF_A, ppi_pkg::INTR_A);
                end
                if (b_hs) begin
                    if (i_state.dir[1] == ppi_pkg::ALL_INPUTS) begin
                        p[2] = ppi_pkg::pin_edge(p[2], i_state.pin[2], i_item.data,
                                                 i_item.pin_mask, ppi_pkg::STB_B,
                                                 ppi_pkg::IBF_B, ppi_pkg::INTR_B);
                    end else begin
                        p[2] = ppi_pkg::pin_edge(p[2], i_state.pin[2], i_item.data,
                                                 i_item.pin_mask, ppi_pkg::ACK_B,
                                                 ppi_pkg::OBF_B, ppi_pkg::INTR_B);
                    end
                end
                st.pin[2] = (i_state.pin[2] & ~i_item.pin_mask) |
                            (i_item.data & i_item.pin_mask);
            end
            ppi_pkg::ACT_RESET_LINE: begin
                // A low reset line restores modes, directions and first-write flags only.
                if ((i_item.data & i_item.pin_mask) == 8'h00) begin
                    st.a_mode = ppi_pkg::MODE_A_BASIC;
                    st.b_mode = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        st.dir[i] = ppi_pkg::ALL_INPUTS;
                        p[i].fw   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        for (int i = 0; i < 3; i++) begin
            st.lat[i] = p[i].lat;
            st.fw[i]  = p[i].fw;
        end
    end

    assign o_state                = st;
    assign o_result.read_data     = rd;
    assign o_result.port_a_drive  = p[0].lat;
    assign o_result.port_b_drive  = p[1].lat;
    assign o_result.port_c_drive  = p[2].lat;
    assign o_result.drive_updated = {p[2].drv, p[1].drv, p[0].drv};

endmodule

@@ hdl/parallel_port_interface.sv @@
// Top level of the three-port parallel interface: input register, state and result register.
//
//   channel   direction  carries
//   i_cmd     in         action, address, data, pin_mask
//   o_rsp     out        read_data, port drives, drive_updated
//   i_cfg     in         clear_on_mode_set
//
// One word is taken per cycle while the result is not stalled; it waits in the input register.
// All port state is worked out by the combinational core and registered with the result,
// so back-to-back words see each other's effects at once.
// A stalled result holds the result register and, through it, the input register.
// Reset clears the latches, sets all ports to input and marks the first write pending.
`include "parallel_port_interface_macros.svh"

module parallel_port_interface (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppi_cmd_if.sink   i_cmd,
    ppi_rsp_if.source o_rsp,
    ppi_cfg_if.sink   i_cfg
);

    ppi_pkg::t_item   r_in;
    logic             r_in_valid;
    ppi_pkg::t_result r_out;
    ppi_pkg::t_result n_out;
    logic             r_out_valid;
    ppi_pkg::t_state  r_st;
    ppi_pkg::t_state  n_st;
    logic             r_clear;
    logic             advance;
    logic             in_ready;
    logic             drive_c;
    logic             rst_line_low;
    logic             ctrl_rd;

    assign advance  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_cmd.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    ppi_core u_core (
        .i_state             (r_st),
        .i_item              (r_in),
        .i_clear_on_mode_set (r_clear),
        .o_state             (n_st),
        .o_result            (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clear     <= 1'b0;
            r_st.lat    <= '0;
            r_st.pin    <= '0;
            r_st.dir    <= {3{ppi_pkg::ALL_INPUTS}};
            r_st.a_mode <= ppi_pkg::MODE_A_BASIC;
            r_st.b_mode <= 1'b0;
            r_st.fw     <= 3'b111;
        end else begin
            if (in_ready) r_in_valid <= i_cmd.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) r_clear <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd.valid) begin
            r_in.action   <= i_cmd.action;
            r_in.address  <= i_cmd.address;
            r_in.data     <= i_cmd.data;
            r_in.pin_mask <= i_cmd.pin_mask;
        end
        if (advance) r_out <= n_out;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out.read_data;
    assign o_rsp.port_a_drive  = r_out.port_a_drive;
    assign o_rsp.port_b_drive  = r_out.port_b_drive;
    assign o_rsp.port_c_drive  = r_out.port_c_drive;
    assign o_rsp.drive_updated = r_out.drive_updated;

    assign drive_c      = advance && n_out.drive_updated[2];
    assign rst_line_low = advance && r_in.action == ppi_pkg::ACT_RESET_LINE &&
                          (r_in.data & r_in.pin_mask) == 8'h00;
    assign ctrl_rd      = advance && r_in.action == ppi_pkg::ACT_BUS_READ &&
                          r_in.address == ppi_pkg::ADDR_CONTROL;

    // Ports A and B are always wholly input or wholly output.
    `PPI_ASSERT_NOW(a_dir_whole, i_clk, i_rst_n, r_st.dir[0] == 8'h00 || r_st.dir[0] == 8'hff)
    `PPI_ASSERT_NOW(b_dir_whole, i_clk, i_rst_n, r_st.dir[1] == 8'h00 || r_st.dir[1] == 8'hff)
    // A driven port C has had its first write.
    `PPI_ASSERT_NEXT(drive_clears_first, i_clk, i_rst_n, drive_c, !r_st.fw[2])
    // A low reset line puts both groups back into basic mode.
    `PPI_ASSERT_NEXT(reset_line_modes, i_clk, i_rst_n, rst_line_low, r_st.a_mode == ppi_pkg::MODE_A_BASIC && !r_st.b_mode)
    // A read of the control address always returns all ones.
    `PPI_ASSERT_NEXT(ctrl_read_ones, i_clk, i_rst_n, ctrl_rd, r_out.read_data == ppi_pkg::CTRL_READ)

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench of the parallel port interface: directed table, then random words checked by a port model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppi_pkg::*;

    localparam logic [2:0] ACT_IGNORED_6 = 3'd6;
    localparam logic [2:0] ACT_IGNORED_7 = 3'd7;

    // Control word fields.
    localparam logic [7:0] CW_MODE_SET = 8'h80;
    localparam logic [7:0] CW_A_BIDIR  = 8'h40;
    localparam logic [7:0] CW_A_STROBE = 8'h20;
    localparam logic [7:0] CW_A_INPUT  = 8'h10;
    localparam logic [7:0] CW_CU_INPUT = 8'h08;
    localparam logic [7:0] CW_B_STROBE = 8'h04;
    localparam logic [7:0] CW_B_INPUT  = 8'h02;
    localparam logic [7:0] CW_CL_INPUT = 8'h01;

    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 200;

    typedef struct {
        bit      set_clear;
        t_item   w;
        bit      typed;
        t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ppi_cmd_if cmd_ch();
    ppi_rsp_if rsp_ch();
    ppi_cfg_if cfg_ch();

    parallel_port_interface i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Port model state.
    logic [7:0] sim_lat [0:2];
    logic [7:0] sim_pin [0:2];
    logic [7:0] sim_dir [0:2];
    logic [1:0] sim_a_mode;
    logic       sim_b_mode;
    logic [2:0] sim_first;
    logic       sim_clear;
    logic [2:0] sim_driven;

    t_result     due_results[$];
    t_row        plan[$];
    int unsigned fails;
    int unsigned results_seen;
    int unsigned live_words;
    int unsigned cfg_writes;
    int unsigned act_count [0:7];
    int unsigned cycles;
    bit          quiet;
    bit          burst_on;
    bit          long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void drive_latch(logic [1:0] ch, logic [7:0] v);
        if (sim_lat[ch] != v || sim_first[ch]) begin
            sim_lat[ch]    = v;
            sim_first[ch]  = 1'b0;
            sim_driven[ch] = 1'b1;
        end
    endfunction

    function automatic bit a_strobed();
        return sim_a_mode == MODE_A_STROBE || sim_a_mode == MODE_A_BIDIR;
    endfunction

    // A latch write clears the output-buffer-full flag of a handshaking port.
    function automatic void latch_write(logic [1:0] ch, logic [7:0] v);
        logic [7:0] c;
        logic [7:0] w;
        drive_latch(ch, v);
        c = sim_lat[ADDR_PORT_C];
        if (ch == ADDR_PORT_A && a_strobed()) begin
            w = c & ~OBF_A;
            if ((c & ACK_A) != 8'h00) w = w & ~INTR_A;
            drive_latch(ADDR_PORT_C, w);
        end else if (ch == ADDR_PORT_B && sim_b_mode) begin
            w = c & ~OBF_B;
            if ((c & ACK_B) != 8'h00) w = w & ~INTR_B;
            drive_latch(ADDR_PORT_C, w);
        end
    endfunction

    function automatic void ctrl_write(logic [7:0] d);
        logic [7:0] v;
        if ((d & CW_MODE_SET) != 8'h00) begin
            if ((d & CW_A_BIDIR) != 8'h00) sim_a_mode = MODE_A_BIDIR;
            else if ((d & CW_A_STROBE) != 8'h00) sim_a_mode = MODE_A_STROBE;
            else sim_a_mode = MODE_A_BASIC;
            sim_dir[ADDR_PORT_A] = (sim_a_mode == MODE_A_BIDIR || (d & CW_A_INPUT) != 8'h00)
                                   ? ALL_INPUTS : 8'h00;
            sim_b_mode = (d & CW_B_STROBE) != 8'h00;
            sim_dir[ADDR_PORT_B] = ((d & CW_B_INPUT) != 8'h00) ? ALL_INPUTS : 8'h00;
            sim_dir[ADDR_PORT_C] = {((d & CW_CU_INPUT) != 8'h00) ? 4'hf : 4'h0,
                                    ((d & CW_CL_INPUT) != 8'h00) ? 4'hf : 4'h0};
            // The modes are already in force while the latches are cleared.
            if (sim_clear) begin
                latch_write(ADDR_PORT_A, 8'h00);
                latch_write(ADDR_PORT_B, 8'h00);
                latch_write(ADDR_PORT_C, 8'h00);
            end
            if (sim_a_mode != MODE_A_BASIC || sim_b_mode) begin
                v = sim_lat[ADDR_PORT_C];
                if (a_strobed()) v = (v & ~IBF_A & ~INTR_A) | OBF_A;
                if (sim_b_mode) begin
                    if (sim_dir[ADDR_PORT_B] == ALL_INPUTS) v = v & ~IBF_B;
                    else v = v | OBF_B;
                    v = v & ~INTR_B;
                end
                drive_latch(ADDR_PORT_C, v);
            end
        end else begin
            v = sim_lat[ADDR_PORT_C];
            v[d[3:1]] = d[0];
            drive_latch(ADDR_PORT_C, v);
        end
    endfunction

    function automatic logic [7:0] bus_fetch(logic [1:0] ch);
        logic [7:0] c;
        logic [7:0] w;
        if (ch == ADDR_CONTROL) return CTRL_READ;
        c = sim_lat[ADDR_PORT_C];
        if (ch == ADDR_PORT_A && a_strobed()) begin
            w = c & ~IBF_A;
            if ((c & STB_A) != 8'h00) w = w & ~INTR_A;
            drive_latch(ADDR_PORT_C, w);
        end else if (ch == ADDR_PORT_B && sim_b_mode) begin
            w = c & ~IBF_B;
            if ((c & STB_B) != 8'h00) w = w & ~INTR_B;
            drive_latch(ADDR_PORT_C, w);
        end
        return (sim_pin[ch] & sim_dir[ch]) | (sim_lat[ch] & ~sim_dir[ch]);
    endfunction

    // A falling pin raises the flag; a rising pin raises the interrupt when the
    // latch bit at the pin's own position enables it.
    function automatic void strobe_edge(logic [7:0] old, logic [7:0] d, logic [7:0] m,
                                        logic [7:0] pin, logic [7:0] flag, logic [7:0] intr);
        if ((m & pin) != 8'h00) begin
            if ((old & pin) != 8'h00 && (d & pin) == 8'h00) begin
                drive_latch(ADDR_PORT_C, sim_lat[ADDR_PORT_C] | flag);
            end else if ((old & pin) == 8'h00 && (d & pin) != 8'h00 &&
                         (sim_lat[ADDR_PORT_C] & pin) != 8'h00) begin
                drive_latch(ADDR_PORT_C, sim_lat[ADDR_PORT_C] | intr);
            end
        end
    endfunction

    function automatic void soft_clear();
        for (int i = 0; i < 3; i++) sim_dir[i] = ALL_INPUTS;
        sim_first  = 3'b111;
        sim_a_mode = MODE_A_BASIC;
        sim_b_mode = 1'b0;
    endfunction

    function automatic t_result port_state_step(t_item w);
        t_result    r;
        logic [7:0] old_c;
        logic [7:0] rd;
        sim_driven = 3'b000;
        rd         = 8'h00;
        old_c      = sim_pin[ADDR_PORT_C];
        case (w.action)
            ACT_BUS_WRITE: begin
                if (w.address == ADDR_CONTROL) ctrl_write(w.data);
                else latch_write(w.address, w.data);
            end
            ACT_BUS_READ: rd = bus_fetch(w.address);
            ACT_PINS_A: sim_pin[ADDR_PORT_A] = (sim_pin[ADDR_PORT_A] & ~w.pin_mask) |
                                               (w.data & w.pin_mask);
            ACT_PINS_B: sim_pin[ADDR_PORT_B] = (sim_pin[ADDR_PORT_B] & ~w.pin_mask) |
                                               (w.data & w.pin_mask);
            ACT_PINS_C: begin
                if (a_strobed()) begin
                    strobe_edge(old_c, w.data, w.pin_mask, STB_A, IBF_A, INTR_A);
                    strobe_edge(old_c, w.data, w.pin_mask, ACK_A, OBF_A, INTR_A);
                end
                if (sim_b_mode) begin
                    if (sim_dir[ADDR_PORT_B] == ALL_INPUTS)
                        strobe_edge(old_c, w.data, w.pin_mask, STB_B, IBF_B, INTR_B);
                    else
                        strobe_edge(old_c, w.data, w.pin_mask, ACK_B, OBF_B, INTR_B);
                end
                sim_pin[ADDR_PORT_C] = (old_c & ~w.pin_mask) | (w.data & w.pin_mask);
            end
            ACT_RESET_LINE: begin
                if ((w.data & w.pin_mask) == 8'h00) soft_clear();
            end
            default: ;
        endcase
        r.read_data     = rd;
        r.port_a_drive  = sim_lat[ADDR_PORT_A];
        r.port_b_drive  = sim_lat[ADDR_PORT_B];
        r.port_c_drive  = sim_lat[ADDR_PORT_C];
        r.drive_updated = sim_driven;
        return r;
    endfunction

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic t_item mk_word(logic [2:0] act, logic [1:0] adr, logic [7:0] d,
                                      logic [7:0] m);
        t_item w;
        w.action   = act;
        w.address  = adr;
        w.data     = d;
        w.pin_mask = m;
        return w;
    endfunction

    function automatic t_result shown(logic [7:0] rd, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] c, logic [2:0] drv);
        return {rd, a, b, c, drv};
    endfunction

    function automatic t_row row(bit set_clear, logic [2:0] act, logic [1:0] adr,
                                 logic [7:0] d, logic [7:0] m, bit typed, t_result want);
        t_row r;
        r.set_clear = set_clear;
        r.w         = mk_word(act, adr, d, m);
        r.typed     = typed;
        r.want      = want;
        return r;
    endfunction

    function automatic t_item pick_word();
        t_item       w;
        int unsigned r;
        r = $urandom_range(0, 99);
        w = mk_word(ACT_BUS_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        if (r < 28) begin
            w.action = ACT_BUS_WRITE;
            if ($urandom_range(0, 2) == 0) begin
                w.address = ADDR_CONTROL;
                if ($urandom_range(0, 1) == 0) w.data = w.data | CW_MODE_SET;
                else w.data = w.data & ~CW_MODE_SET;
            end
        end else if (r < 57) begin
            w.action = ACT_PINS_A;
        end else if (r < 64) begin
            w.action = ACT_PINS_B;
        end else if (r < 90) begin
            w.action = ACT_PINS_C;
            case ($urandom_range(0, 3))
                0: w.pin_mask = STB_A;
                1: w.pin_mask = ACK_A;
                2: w.pin_mask = STB_B;
                default: ;
            endcase
        end else if (r < 97) begin
            w.action = ACT_RESET_LINE;
            // Mostly a high line, since a low one throws the modes away.
            if ($urandom_range(0, 4) != 0) begin
                w.data     = w.data | 8'h01;
                w.pin_mask = w.pin_mask | 8'h01;
            end
        end else begin
            w.action = ($urandom_range(0, 1) == 0) ? ACT_IGNORED_6 : ACT_IGNORED_7;
        end
        if (r >= 28 && r < 50) w.action = ACT_BUS_READ;
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb: mismatch: %s", msg);
        fails++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %02h, expected %02h",
                                      results_seen, name, got, want));
    endtask

    task automatic send_word(t_item w, bit typed, t_result want);
        int      gap;
        t_result calc;
        gap = (quiet || burst_on) ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.action   <= w.action;
        cmd_ch.address  <= w.address;
        cmd_ch.data     <= w.data;
        cmd_ch.pin_mask <= w.pin_mask;
        do @(posedge i_clk); while (!cmd_ch.ready);
        calc = port_state_step(w);
        due_results.push_back(typed ? want : calc);
        act_count[w.action]++;
        if (w.action <= ACT_RESET_LINE) live_words++;
    endtask

    // Only written once the block has handed back every word.
    task automatic write_clear_cfg(bit v);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sim_clear = v;
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mode set, enable bit, strobe pin edges, then the port access that answers them.
    task automatic handshake_run();
        logic [7:0] hs;
        logic [7:0] mode;
        logic [2:0] idx;
        logic [1:0] port;
        case ($urandom_range(0, 2))
            0: hs = STB_A;
            1: hs = ACK_A;
            default: hs = STB_B;
        endcase
        idx = 3'd0;
        for (int i = 0; i < 8; i++) if (hs[i]) idx = 3'(i);
        mode = CW_MODE_SET | 8'($urandom_range(0, 127));
        if (hs == STB_B) mode = mode | CW_B_STROBE;
        else if ((mode & (CW_A_BIDIR | CW_A_STROBE)) == 8'h00) mode = mode | CW_A_STROBE;
        port = (hs == STB_B) ? ADDR_PORT_B : ADDR_PORT_A;
        send_word(mk_word(ACT_BUS_WRITE, ADDR_CONTROL, mode, 8'h00), 1'b0, '0);
        send_word(mk_word(ACT_BUS_WRITE, ADDR_CONTROL, {4'h0, idx, 1'b1}, 8'h00), 1'b0, '0);
        send_word(mk_word(ACT_PINS_C, 2'($urandom_range(0, 3)), hs, hs), 1'b0, '0);
        send_word(mk_word(ACT_PINS_C, 2'($urandom_range(0, 3)), 8'h00, hs), 1'b0, '0);
        send_word(mk_word(ACT_PINS_C, 2'($urandom_range(0, 3)), hs, hs), 1'b0, '0);
        send_word(mk_word(ACT_BUS_READ, port, 8'h00, 8'h00), 1'b0, '0);
        send_word(mk_word(ACT_BUS_WRITE, port, 8'($urandom_range(0, 255)), 8'h00), 1'b0, '0);
        send_word(mk_word(ACT_BUS_READ, ADDR_PORT_C, 8'h00, 8'h00), 1'b0, '0);
    endtask

    initial begin : stimulus
        int unsigned target;
        cmd_ch.valid    = 1'b0;
        cmd_ch.action   = ACT_BUS_READ;
        cmd_ch.address  = ADDR_PORT_A;
        cmd_ch.data     = 8'h00;
        cmd_ch.pin_mask = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = 1'b0;
        i_rst_n         = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sim_lat[i] = 8'h00;
            sim_pin[i] = 8'h00;
        end
        soft_clear();
        sim_clear  = 1'b0;
        sim_driven = 3'b000;
        for (int i = 0; i < 8; i++) act_count[i] = 0;

        plan.push_back(row(0, ACT_BUS_READ, ADDR_PORT_A, 8'h00, 8'h00, 1,
                           shown(8'h00, 8'h00, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_BUS_READ, ADDR_CONTROL, 8'hff, 8'hff, 1,
                           shown(8'hff, 8'h00, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_IGNORED_6, ADDR_PORT_C, 8'hff, 8'hff, 1,
                           shown(8'h00, 8'h00, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_IGNORED_7, ADDR_PORT_A, 8'h00, 8'h00, 1,
                           shown(8'h00, 8'h00, 8'h00, 8'h00, 3'b000)));
        // The first write after reset drives the port; rewriting the same value does not.
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_PORT_A, 8'hff, 8'h00, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b001)));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_PORT_A, 8'hff, 8'hff, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_PINS_A, ADDR_PORT_A, 8'h0f, 8'hff, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_BUS_READ, ADDR_PORT_A, 8'h00, 8'h00, 1,
                           shown(8'h0f, 8'hff, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL, CW_MODE_SET, 8'h00, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_BUS_READ, ADDR_PORT_A, 8'h00, 8'h00, 1,
                           shown(8'hff, 8'hff, 8'h00, 8'h00, 3'b000)));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_PORT_B, 8'h00, 8'hff, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b010)));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_PORT_C, 8'h00, 8'h00, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b100)));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL, 8'h0f, 8'h00, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h80, 3'b100)));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL, 8'h0e, 8'h00, 1,
                           shown(8'h00, 8'hff, 8'h00, 8'h00, 3'b100)));
        plan.push_back(row(0, ACT_PINS_B, ADDR_PORT_B, 8'h5a, 8'hf0, 0, '0));
        plan.push_back(row(0, ACT_RESET_LINE, ADDR_PORT_A, 8'h00, 8'hff, 0, '0));
        plan.push_back(row(0, ACT_BUS_READ, ADDR_PORT_B, 8'h00, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL,
                           CW_MODE_SET | CW_A_STROBE | CW_B_STROBE | CW_B_INPUT, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_PINS_C, ADDR_PORT_C, 8'hff, 8'hff, 0, '0));
        plan.push_back(row(0, ACT_PINS_C, ADDR_PORT_C, 8'h00, 8'hff, 0, '0));
        plan.push_back(row(0, ACT_BUS_READ, ADDR_PORT_B, 8'h00, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL, CW_MODE_SET | CW_A_BIDIR | CW_B_STROBE,
                           8'h00, 0, '0));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL, 8'h0d, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_PINS_C, ADDR_PORT_C, 8'hff, 8'hff, 0, '0));
        plan.push_back(row(0, ACT_BUS_READ, ADDR_PORT_A, 8'h00, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_PORT_B, 8'hc3, 8'h00, 0, '0));
        plan.push_back(row(1, ACT_BUS_WRITE, ADDR_PORT_C, 8'h55, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL,
                           CW_MODE_SET | CW_A_STROBE | CW_B_STROBE | CW_B_INPUT, 8'h00, 0, '0));
        plan.push_back(row(0, ACT_BUS_WRITE, ADDR_CONTROL, CW_MODE_SET | CW_A_INPUT | CW_CU_INPUT |
                           CW_B_INPUT | CW_CL_INPUT, 8'h00, 0, '0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_clear_cfg(1'b0);
        foreach (plan[i]) begin
            if (plan[i].set_clear) write_clear_cfg(1'b1);
            send_word(plan[i].w, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            write_clear_cfg(ph != 1);
            target = live_words + PHASE_WORDS;
            while (live_words < target) begin
                quiet    = (ph == 1) && (live_words + 140 > target);
                burst_on = (ph == 2) && (live_words + 80 > target);
                if ($urandom_range(0, 9) == 0) handshake_run();
                else send_word(pick_word(), 1'b0, '0);
            end
            quiet    = 1'b0;
            burst_on = 1'b0;
        end

        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("tb: %0d words sent: %0d writes, %0d reads, %0d pin events, %0d reset-line, %0d ignored",
                 live_words + act_count[ACT_IGNORED_6] + act_count[ACT_IGNORED_7],
                 act_count[ACT_BUS_WRITE], act_count[ACT_BUS_READ],
                 act_count[ACT_PINS_A] + act_count[ACT_PINS_B] + act_count[ACT_PINS_C],
                 act_count[ACT_RESET_LINE], act_count[ACT_IGNORED_6] + act_count[ACT_IGNORED_7]);
        $display("tb: %0d results checked, %0d clear-on-mode-set writes, long output stall %s",
                 results_seen, cfg_writes, long_hold_done ? "seen" : "missed");
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : drain
        int stall_left;
        stall_left     = 0;
        long_hold_done = 1'b0;
        rsp_ch.ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst_on && !long_hold_done) begin
                // Hold the output long enough for the block to fill and refuse words.
                rsp_ch.ready <= 1'b0;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else if (quiet || stall_left == 0) begin
                rsp_ch.ready <= 1'b1;
                if (!quiet) stall_left = idle_len();
            end else begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.read_data, rsp_ch.port_a_drive, rsp_ch.port_b_drive,
                   rsp_ch.port_c_drive, rsp_ch.drive_updated};
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = due_results.pop_front();
                check_field("read_data", got.read_data, want.read_data);
                check_field("port_a_drive", got.port_a_drive, want.port_a_drive);
                check_field("port_b_drive", got.port_b_drive, want.port_b_drive);
                check_field("port_c_drive", got.port_c_drive, want.port_c_drive);
                check_field("drive_updated", {5'b00000, got.drive_updated},
                            {5'b00000, want.drive_updated});
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timed out with %0d results outstanding", due_results.size());
            $display("tb: failure");
            $finish;
        end
    end

endmodule
